>>> rtl/thlpt_pkg.sv
// Shared types and constants for the triple hash linear probe table unit.
// No dependencies.
`timescale 1ns / 1ps

package thlpt_pkg;

  // Default table depth
  localparam int SLOTS_DEF = 64;

  // Register reset values
  localparam logic [6:0] TABLE_SIZE_RST  = 7'd64;
  localparam logic [6:0] PRIME_MOD_RST   = 7'd61;
  localparam logic [6:0] PROBE_LIMIT_RST = 7'd8;

  // Hash seeds and masks
  localparam logic [31:0] TIME33_SEED = 32'd5381;
  localparam logic [31:0] ELF_TOP     = 32'hF000_0000;
  localparam logic [31:0] HASH31_MASK = 32'h7FFF_FFFF;
  localparam logic [31:0] BKDR_MUL    = 32'd131;

  // Configuration register indexes
  localparam logic [1:0] CFG_TABLE_SIZE  = 2'd0;
  localparam logic [1:0] CFG_PRIME_MOD   = 2'd1;
  localparam logic [1:0] CFG_PROBE_LIMIT = 2'd2;

  // Opcodes
  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FULL      = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;

  // One table entry
  typedef struct packed {
    logic        valid;
    logic [31:0] h33;
    logic [30:0] helf;
    logic [30:0] hbkdr;
    logic [31:0] payload;
  } entry_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_MOD1,
    S_MOD2,
    S_READ,
    S_CHECK,
    S_DONE
  } state_t;

endpackage

>>> rtl/triple_hash_linear_probe_table_unit.sv
// Top level of the triple hash linear probe table unit.
// Depends on thlpt_pkg.
`timescale 1ns / 1ps

// Key bytes are taken one per cycle while the unit is idle and folded into
// time33, ELF and BKDR hashes; a zero byte ends the key and runs add, remove
// or lookup on a table held in one single-port-write synchronous memory. A
// terminator first reduces the start index in a bit-serial remainder unit,
// first by prime_modulus, then by table_size, then for each slot visited
// reads the memory and then checks and writes back, and at the end hands
// over the result. After reset the unit clears the table memory, one entry
// per cycle, before it takes items.
module triple_hash_linear_probe_table_unit #(
  parameter int SLOTS = thlpt_pkg::SLOTS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_key_byte,
  input  logic [1:0]  in_opcode,
  input  logic [31:0] in_payload,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic        out_found,
  output logic [5:0]  out_slot_index,
  output logic [31:0] out_stored_payload,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [6:0]  cfg_data
);

  localparam int IW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int SZW = (CW > 7) ? CW : 7;

  thlpt_pkg::state_t state_r, state_nxt;

  // Configuration
  logic [6:0] table_size_r, prime_mod_r, probe_limit_r;

  // Running hashes
  logic [31:0] acc33_r, accelf_r, accbk_r;
  logic [31:0] elf_sum, elf_top;

  // Latched key hashes and operation
  logic [31:0] k33_r;
  logic [30:0] kelf_r, kbk_r;
  logic [1:0]  op_r;
  logic [31:0] pay_r;

  // Remainder unit
  logic [31:0]    q_r, q_nxt;
  logic [SZW:0]   rem_r, rem_nxt, rem_sh;
  logic [SZW:0]   div_r, div_nxt;
  logic [4:0]     bit_r, bit_nxt;

  // Walk
  logic [IW-1:0]  s_r, s_nxt;
  logic [CW-1:0]  cnt_r, cnt_nxt;
  logic [CW-1:0]  size_w;
  logic [SZW-1:0] ts_ext;
  logic [7:0]     miss_r, miss_nxt;

  // Memory
  thlpt_pkg::entry_t mem [SLOTS];
  thlpt_pkg::entry_t rdata_r, wdata;
  logic              we;
  logic [IW-1:0]     waddr;

  // Result
  logic [1:0]  res_status_r, res_status_nxt;
  logic        res_found_r, res_found_nxt;
  logic [IW-1:0] res_slot_r, res_slot_nxt;
  logic [31:0] res_pay_r, res_pay_nxt;
  logic        load_out;

  logic in_acc, match;

  assign in_acc = in_valid && in_ready;
  assign in_ready = (state_r == thlpt_pkg::S_IDLE);

  // Effective table size: zero reads as one, cap at SLOTS
  always_comb begin
    ts_ext = SZW'(table_size_r);
    if (table_size_r == 7'd0) begin
      size_w = CW'(1);
    end else if (ts_ext > SZW'(SLOTS)) begin
      size_w = CW'(SLOTS);
    end else begin
      size_w = CW'(ts_ext);
    end
  end

  // ELF step
  assign elf_sum = {accelf_r[27:0], 4'd0} + {24'd0, in_key_byte};
  assign elf_top = elf_sum & thlpt_pkg::ELF_TOP;

  assign match = (rdata_r.h33 == k33_r) && (rdata_r.helf == kelf_r) &&
                 (rdata_r.hbkdr == kbk_r);

  assign rem_sh = {rem_r[SZW-1:0], q_r[31]};

  // Next state and walk control
  always_comb begin
    state_nxt      = state_r;
    q_nxt          = q_r;
    rem_nxt        = rem_r;
    div_nxt        = div_r;
    bit_nxt        = bit_r;
    s_nxt          = s_r;
    cnt_nxt        = cnt_r;
    miss_nxt       = miss_r;
    res_status_nxt = res_status_r;
    res_found_nxt  = res_found_r;
    res_slot_nxt   = res_slot_r;
    res_pay_nxt    = res_pay_r;
    we             = 1'b0;
    waddr          = s_r;
    wdata          = rdata_r;
    load_out       = 1'b0;
    unique case (state_r)
      thlpt_pkg::S_CLEAR: begin
        we    = 1'b1;
        waddr = IW'(cnt_r);
        wdata = '0;
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(SLOTS - 1)) begin
          state_nxt = thlpt_pkg::S_IDLE;
        end
      end
      thlpt_pkg::S_IDLE: begin
        if (in_acc && in_key_byte == 8'd0) begin
          q_nxt   = acc33_r;
          rem_nxt = '0;
          div_nxt = (prime_mod_r == 7'd0) ? (SZW+1)'(1) : (SZW+1)'(prime_mod_r);
          bit_nxt = 5'd31;
          state_nxt = thlpt_pkg::S_MOD1;
        end
      end
      thlpt_pkg::S_MOD1, thlpt_pkg::S_MOD2: begin
        rem_nxt = (rem_sh >= div_r) ? rem_sh - div_r : rem_sh;
        q_nxt   = {q_r[30:0], 1'b0};
        bit_nxt = bit_r - 5'd1;
        if (bit_r == 5'd0) begin
          if (state_r == thlpt_pkg::S_MOD1) begin
            // Second pass: start index modulo table size
            q_nxt   = {rem_nxt[6:0], 25'd0};
            rem_nxt = '0;
            div_nxt = (SZW+1)'(size_w);
            bit_nxt = 5'd6;
            state_nxt = thlpt_pkg::S_MOD2;
          end else begin
            s_nxt    = IW'(rem_nxt);
            cnt_nxt  = '0;
            miss_nxt = '0;
            state_nxt = thlpt_pkg::S_READ;
          end
        end
      end
      thlpt_pkg::S_READ: begin
        state_nxt = thlpt_pkg::S_CHECK;
      end
      thlpt_pkg::S_CHECK: begin
        res_found_nxt = 1'b0;
        res_slot_nxt  = '0;
        res_pay_nxt   = '0;
        if (!rdata_r.valid && op_r == thlpt_pkg::OP_ADD) begin
          // Fill the first free slot
          we = 1'b1;
          wdata.valid   = 1'b1;
          wdata.h33     = k33_r;
          wdata.helf    = kelf_r;
          wdata.hbkdr   = kbk_r;
          wdata.payload = pay_r;
          res_status_nxt = thlpt_pkg::ST_OK;
          res_slot_nxt   = s_r;
          state_nxt = thlpt_pkg::S_DONE;
        end else if (rdata_r.valid && op_r != thlpt_pkg::OP_ADD && match) begin
          res_status_nxt = thlpt_pkg::ST_OK;
          res_found_nxt  = 1'b1;
          res_slot_nxt   = s_r;
          if (op_r == thlpt_pkg::OP_REMOVE) begin
            we = 1'b1;
            wdata.valid = 1'b0;
          end else begin
            res_pay_nxt = rdata_r.payload;
          end
          state_nxt = thlpt_pkg::S_DONE;
        end else begin
          res_status_nxt = (op_r == thlpt_pkg::OP_ADD) ? thlpt_pkg::ST_FULL
                                                        : thlpt_pkg::ST_NOT_FOUND;
          if (rdata_r.valid) begin
            miss_nxt = miss_r + 8'd1;
          end
          cnt_nxt = cnt_r + CW'(1);
          if (rdata_r.valid && miss_nxt > {1'b0, probe_limit_r}) begin
            state_nxt = thlpt_pkg::S_DONE;
          end else if (cnt_nxt == size_w) begin
            state_nxt = thlpt_pkg::S_DONE;
          end else begin
            s_nxt = ((CW'(s_r) + CW'(1)) == size_w) ? '0 : s_r + IW'(1);
            state_nxt = thlpt_pkg::S_READ;
          end
        end
      end
      thlpt_pkg::S_DONE: begin
        if (!out_valid || out_ready) begin
          load_out  = 1'b1;
          state_nxt = thlpt_pkg::S_IDLE;
        end
      end
      default: state_nxt = thlpt_pkg::S_IDLE;
    endcase
  end

  // Table memory
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[s_r];
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= thlpt_pkg::S_CLEAR;
      cnt_r         <= '0;
      out_valid     <= 1'b0;
      table_size_r  <= thlpt_pkg::TABLE_SIZE_RST;
      prime_mod_r   <= thlpt_pkg::PRIME_MOD_RST;
      probe_limit_r <= thlpt_pkg::PROBE_LIMIT_RST;
      acc33_r       <= thlpt_pkg::TIME33_SEED;
      accelf_r      <= '0;
      accbk_r       <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      // Configuration writes
      if (cfg_we) begin
        unique case (cfg_index)
          thlpt_pkg::CFG_TABLE_SIZE:  table_size_r  <= cfg_data;
          thlpt_pkg::CFG_PRIME_MOD:   prime_mod_r   <= cfg_data;
          thlpt_pkg::CFG_PROBE_LIMIT: probe_limit_r <= cfg_data;
          default: ;
        endcase
      end
      // Hash a key byte, restart on the terminator
      if (in_acc) begin
        if (in_key_byte != 8'd0) begin
          acc33_r  <= {acc33_r[26:0], 5'd0} + acc33_r + {24'd0, in_key_byte};
          accelf_r <= (elf_top != 32'd0) ? ((elf_sum ^ (elf_top >> 24)) & ~elf_top)
                                         : elf_sum;
          accbk_r  <= accbk_r * thlpt_pkg::BKDR_MUL + {24'd0, in_key_byte};
        end else begin
          acc33_r  <= thlpt_pkg::TIME33_SEED;
          accelf_r <= '0;
          accbk_r  <= '0;
        end
      end
      // Hold a result until taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    q_r          <= q_nxt;
    rem_r        <= rem_nxt;
    div_r        <= div_nxt;
    bit_r        <= bit_nxt;
    s_r          <= s_nxt;
    miss_r       <= miss_nxt;
    res_status_r <= res_status_nxt;
    res_found_r  <= res_found_nxt;
    res_slot_r   <= res_slot_nxt;
    res_pay_r    <= res_pay_nxt;
    if (in_acc && in_key_byte == 8'd0) begin
      k33_r  <= acc33_r;
      kelf_r <= accelf_r[30:0];
      kbk_r  <= accbk_r[30:0];
      op_r   <= in_opcode;
      pay_r  <= in_payload;
    end
    if (load_out) begin
      out_status         <= res_status_r;
      out_found          <= res_found_r;
      out_slot_index     <= 6'(res_slot_r);
      out_stored_payload <= res_pay_r;
    end
  end

endmodule
